FILE: design/waypoint_path_follower_macros.svh
// ----------------------------------------------------------------------------
// waypoint path follower assertion macros
// short forms for the concurrent checks of the top level
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_PATH_FOLLOWER_MACROS_SVH
`define WAYPOINT_PATH_FOLLOWER_MACROS_SVH

// same-cycle implication
`define WPF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("wpf check failed");

// next-cycle implication
`define WPF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("wpf check failed");

`endif

FILE: design/wpf_pkg.sv
// ----------------------------------------------------------------------------
// wpf_pkg
// shared constants and codes of the waypoint path follower
// ----------------------------------------------------------------------------
package wpf_pkg;

	localparam int MAX_POINTS = 16;
	localparam int COORD_BITS = 32;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int WAY_W      = 96;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	// control of an iterative unit
	typedef struct packed {
		logic start;
		logic busy;
	} unit_ctl_t;

endpackage

FILE: design/wpf_ram.sv
// ----------------------------------------------------------------------------
// wpf_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module wpf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/wpf_sqrt.sv
// ----------------------------------------------------------------------------
// wpf_sqrt
// floor square root of a 64 bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module wpf_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [63:0]        radicand,
	output wpf_pkg::unit_ctl_t ctl,
	output logic [31:0]        root
);

	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [63:0] val_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [35:0] r2;
	logic [35:0] trial;
	logic        fit;

	always_comb begin
		r2    = {rem_q, val_q[63:62]};
		trial = {2'b00, root_q, 2'b01};
		fit   = (r2 >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			root_q <= '0;
			val_q  <= radicand;
		end else if (busy_q) begin
			val_q <= {val_q[61:0], 2'b00};
			if (fit) begin
				rem_q  <= 34'(r2 - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= r2[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign root      = root_q;

endmodule

FILE: design/wpf_div.sv
// ----------------------------------------------------------------------------
// wpf_div
// restoring divider, 64 bit dividend by 32 bit divisor, quotient below 2^32
// ----------------------------------------------------------------------------
module wpf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [63:0]        dividend,
	input  logic [31:0]        divisor,
	output wpf_pkg::unit_ctl_t ctl,
	output logic [31:0]        quotient
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] div_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [32:0] r2;
	logic        fit;

	always_comb begin
		r2  = {rem_q, quo_q[31]};
		fit = (r2 >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[63:32];
			quo_q <= dividend[31:0];
			div_q <= divisor;
		end else if (busy_q) begin
			if (fit) begin
				rem_q <= 32'(r2 - {1'b0, div_q});
			end else begin
				rem_q <= r2[31:0];
			end
			quo_q <= {quo_q[30:0], fit};
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign quotient  = quo_q;

endmodule

FILE: design/waypoint_path_follower.sv
// ----------------------------------------------------------------------------
// waypoint_path_follower
// moves one point along a stored polyline of waypoints, one result per item
//
// channel  direction  handshake              payload
// in       into       in_valid / in_stall    kind point_index point_x point_y
//                                            seg_speed tick_dt
// out      out of     out_valid / out_stall  pos_x pos_y segment done_res
// cfg      into       cfg_wr_en              cfg_wr_data (point count)
//
// load, unknown kind and a tick while idle or done: straight to the output state
// start: one waypoint memory read (entry 0) sets the position
// moving tick: two waypoint reads, then the 32-step square root and two
// 32-step divisions that share one divider
// no clearing pass after reset; one item is worked on at a time
// a finished result waits in the output register while the next item is taken
// ----------------------------------------------------------------------------
`include "waypoint_path_follower_macros.svh"

module waypoint_path_follower (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [4:0]               cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               kind,
	input  logic [3:0]               point_index,
	input  logic signed [31:0]       point_x,
	input  logic signed [31:0]       point_y,
	input  logic [31:0]              seg_speed,
	input  logic [15:0]              tick_dt,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [31:0]       pos_x,
	output logic signed [31:0]       pos_y,
	output logic [3:0]               segment,
	output logic                     done_res
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_ST_RD, ST_ST_CAP, ST_RD0, ST_RD1, ST_CAP, ST_PREP,
		ST_SQA, ST_SQB, ST_HA, ST_HB, ST_SQ_GO, ST_SQ_WAIT, ST_DX_GO,
		ST_DX_WAIT, ST_DY_GO, ST_DY_WAIT, ST_MOVE, ST_BOX, ST_FIN
	} state_t;

	localparam logic signed [33:0] SAT_MAX = (34'sd1 <<< (wpf_pkg::COORD_BITS - 1)) - 34'sd1;
	localparam logic signed [33:0] SAT_MIN = -(34'sd1 <<< (wpf_pkg::COORD_BITS - 1));

	state_t state_q;
	logic [wpf_pkg::CNT_W-1:0] count_q;
	logic [wpf_pkg::CNT_W-1:0] eff;
	logic signed [31:0] cur_x_q, cur_y_q;
	logic [wpf_pkg::IDX_W-1:0] seg_q;
	logic running_q;
	logic [15:0] dt_q;
	logic signed [31:0] x1_q, y1_q, x2_q, y2_q;
	logic [31:0] spd_q, h_q, sx_q, sy_q;
	logic [30:0] a_q, b_q;
	logic negx_q, negy_q, zero_q;
	logic [63:0] asq_q, bsq_q, hax_q, hay_q;
	logic out_valid_q;
	logic signed [31:0] out_x_q, out_y_q;
	logic [3:0] out_seg_q;
	logic out_done_q;

	logic accept, done_now, ram_we;
	logic [wpf_pkg::IDX_W-1:0] raddr;
	logic [wpf_pkg::WAY_W-1:0] rdata;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic signed [32:0] dx, dy;
	logic [32:0] ax, ay;
	logic signed [33:0] nx, ny;
	logic outside;
	logic sq_start, dv_start;
	logic [63:0] dv_num;
	logic [31:0] sq_root, dv_quo;
	wpf_pkg::unit_ctl_t sq_ctl, dv_ctl;

	always_comb begin
		if (count_q < 5'd2) begin
			eff = 5'd2;
		end else if (count_q > 5'(wpf_pkg::MAX_POINTS)) begin
			eff = 5'(wpf_pkg::MAX_POINTS);
		end else begin
			eff = count_q;
		end
		done_now = running_q && (({1'b0, seg_q} + 5'd1) >= eff);
	end

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign ram_we   = accept && (kind == wpf_pkg::KIND_LOAD);

	always_comb begin
		case (state_q)
			ST_ST_RD: raddr = '0;
			ST_RD1:   raddr = seg_q + 4'd1;
			default:  raddr = seg_q;
		endcase
	end

	wpf_ram #(.WIDTH(wpf_pkg::WAY_W), .DEPTH(wpf_pkg::MAX_POINTS)) u_way (
		.clk   (clk),
		.we    (ram_we),
		.waddr (point_index),
		.wdata ({point_x, point_y, seg_speed}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// shared multiplier
	always_comb begin
		case (state_q)
			ST_PREP: begin mul_a = spd_q;          mul_b = {16'd0, dt_q}; end
			ST_SQA:  begin mul_a = {1'b0, a_q};    mul_b = {1'b0, a_q};   end
			ST_SQB:  begin mul_a = {1'b0, b_q};    mul_b = {1'b0, b_q};   end
			ST_HA:   begin mul_a = h_q;            mul_b = {1'b0, a_q};   end
			default: begin mul_a = h_q;            mul_b = {1'b0, b_q};   end
		endcase
		prod = mul_a * mul_b;
	end

	always_comb begin
		dx = $signed({x2_q[31], x2_q}) - $signed({x1_q[31], x1_q});
		dy = $signed({y2_q[31], y2_q}) - $signed({y1_q[31], y1_q});
		ax = dx[32] ? 33'(-dx) : 33'(dx);
		ay = dy[32] ? 33'(-dy) : 33'(dy);
		for (int i = 0; i < 2; i++) begin
			if (ax[32:31] != 2'b00 || ay[32:31] != 2'b00) begin
				ax = ax >> 1;
				ay = ay >> 1;
			end
		end
	end

	always_comb begin
		nx = negx_q ? $signed({{2{cur_x_q[31]}}, cur_x_q}) - $signed({2'b00, sx_q})
		            : $signed({{2{cur_x_q[31]}}, cur_x_q}) + $signed({2'b00, sx_q});
		ny = negy_q ? $signed({{2{cur_y_q[31]}}, cur_y_q}) - $signed({2'b00, sy_q})
		            : $signed({{2{cur_y_q[31]}}, cur_y_q}) + $signed({2'b00, sy_q});
		outside = !(cur_x_q >= ((x1_q < x2_q) ? x1_q : x2_q) &&
		            cur_x_q <= ((x1_q < x2_q) ? x2_q : x1_q) &&
		            cur_y_q >= ((y1_q < y2_q) ? y1_q : y2_q) &&
		            cur_y_q <= ((y1_q < y2_q) ? y2_q : y1_q));
	end

	assign sq_start = (state_q == ST_SQ_GO);
	assign dv_start = (state_q == ST_DX_GO) || (state_q == ST_DY_GO);
	assign dv_num   = (state_q == ST_DX_GO) ? hax_q : hay_q;

	wpf_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (asq_q + bsq_q),
		.ctl      (sq_ctl),
		.root     (sq_root)
	);

	wpf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (dv_num),
		.divisor  (sq_root),
		.ctl      (dv_ctl),
		.quotient (dv_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= 5'd2;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			seg_q       <= '0;
			running_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				count_q <= cfg_wr_data;
			end
			if (out_valid_q && !out_stall && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						dt_q <= tick_dt;
						case (kind)
							wpf_pkg::KIND_START: state_q <= ST_ST_RD;
							wpf_pkg::KIND_TICK:  state_q <= (running_q && !done_now) ? ST_RD0 : ST_FIN;
							default:             state_q <= ST_FIN;
						endcase
					end
				end
				ST_ST_RD:  state_q <= ST_ST_CAP;
				ST_ST_CAP: begin
					cur_x_q   <= rdata[95:64];
					cur_y_q   <= rdata[63:32];
					seg_q     <= '0;
					running_q <= 1'b1;
					state_q   <= ST_FIN;
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: begin
					x1_q    <= rdata[95:64];
					y1_q    <= rdata[63:32];
					spd_q   <= rdata[31:0];
					state_q <= ST_CAP;
				end
				ST_CAP: begin
					x2_q    <= rdata[95:64];
					y2_q    <= rdata[63:32];
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					h_q     <= prod[47:16];
					a_q     <= ax[30:0];
					b_q     <= ay[30:0];
					negx_q  <= dx[32];
					negy_q  <= dy[32];
					zero_q  <= (dx == '0) && (dy == '0);
					state_q <= ST_SQA;
				end
				ST_SQA: begin asq_q <= prod; state_q <= ST_SQB; end
				ST_SQB: begin bsq_q <= prod; state_q <= ST_HA;  end
				ST_HA:  begin hax_q <= prod; state_q <= ST_HB;  end
				ST_HB: begin
					hay_q   <= prod;
					state_q <= zero_q ? ST_BOX : ST_SQ_GO;
				end
				ST_SQ_GO:   state_q <= ST_SQ_WAIT;
				ST_SQ_WAIT: if (!sq_ctl.busy) begin state_q <= ST_DX_GO; end
				ST_DX_GO:   state_q <= ST_DX_WAIT;
				ST_DX_WAIT: begin
					if (!dv_ctl.busy) begin
						sx_q    <= dv_quo;
						state_q <= ST_DY_GO;
					end
				end
				ST_DY_GO:   state_q <= ST_DY_WAIT;
				ST_DY_WAIT: begin
					if (!dv_ctl.busy) begin
						sy_q    <= dv_quo;
						state_q <= ST_MOVE;
					end
				end
				ST_MOVE: begin
					cur_x_q <= (nx > SAT_MAX) ? SAT_MAX[31:0] : (nx < SAT_MIN) ? SAT_MIN[31:0] : nx[31:0];
					cur_y_q <= (ny > SAT_MAX) ? SAT_MAX[31:0] : (ny < SAT_MIN) ? SAT_MIN[31:0] : ny[31:0];
					state_q <= ST_BOX;
				end
				ST_BOX: begin
					if (outside) begin
						seg_q   <= seg_q + 4'd1;
						cur_x_q <= x2_q;
						cur_y_q <= y2_q;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_x_q     <= cur_x_q;
						out_y_q     <= cur_y_q;
						out_seg_q   <= seg_q;
						out_done_q  <= done_now;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = out_x_q;
	assign pos_y     = out_y_q;
	assign segment   = out_seg_q;
	assign done_res  = out_done_q;

	`WPF_ASSERT_NXT(a_one_item, clk, arst_n, accept, in_stall)
	`WPF_ASSERT_IMP(a_sqrt_owner, clk, arst_n, sq_ctl.busy, state_q == ST_SQ_WAIT)
	`WPF_ASSERT_IMP(a_div_owner, clk, arst_n, dv_ctl.busy,
		state_q == ST_DX_WAIT || state_q == ST_DY_WAIT)

endmodule
